>>> sv/fspd_pkg.sv
// Shared types and constants for the fan speed PID duty controller.
package fspd_pkg;

   // Fixed point and field widths.
   localparam int GAIN_FRAC_BITS = 12;
   localparam int DUTY_BITS      = 10;
   localparam int SPEED_W        = 16;
   localparam int GAIN_W         = 16;
   localparam int LIMIT_W        = 15;
   localparam int PULSE_W        = 10;
   localparam int INTEG_W        = 16;

   // Internal arithmetic widths.
   localparam int ERR_W       = SPEED_W + 2;
   localparam int INTEG_SUM_W = ERR_W + 1;
   localparam int DERIV_W     = ERR_W + 1;
   localparam int PROD_W      = 36;
   localparam int STEP_W      = PROD_W - GAIN_FRAC_BITS;
   localparam int NEXT_W      = STEP_W + 1;

   // Speed conversion.
   localparam logic [SPEED_W-1:0] RPM_PER_PULSE = SPEED_W'(60);
   localparam logic [SPEED_W-1:0] SPEED_MAX     = SPEED_W'(60000);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SPEED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_FLOOR     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_CEILING   = 3'd6;

   // Input commands.
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // Input transaction payload.
   typedef struct packed {
      logic               command;
      logic [PULSE_W-1:0] tach_pulses;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [DUTY_BITS-1:0]      duty;
      logic [SPEED_W-1:0]        speed_rpm;
      logic signed [INTEG_W-1:0] error_sum;
   } rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic [SPEED_W-1:0]   target_speed;
      logic [GAIN_W-1:0]    gain_p;
      logic [GAIN_W-1:0]    gain_i;
      logic [GAIN_W-1:0]    gain_d;
      logic [LIMIT_W-1:0]   integral_limit;
      logic [DUTY_BITS-1:0] duty_floor;
      logic [DUTY_BITS-1:0] duty_ceiling;
   } cfg_type;

   // Work passed from the front to the back through the queue.
   typedef struct packed {
      logic                      tick;
      logic                      stop;
      logic signed [PROD_W-1:0]  prod_p;
      logic signed [PROD_W-1:0]  prod_i;
      logic signed [PROD_W-1:0]  prod_d;
      logic [SPEED_W-1:0]        speed_rpm;
      logic signed [INTEG_W-1:0] error_sum;
   } work_type;

endpackage

>>> sv/fan_speed_pid_duty_controller.sv
// Top level of the fan speed PID duty controller.
//
//   Channel   Direction  Handshake                Carries
//   req_      in         req_valid / req_ready    command, tach_pulses
//   rsp_      out        rsp_valid / rsp_ready    duty, speed_rpm, error_sum
//   csr_      in         csr_valid / csr_ready    csr_index, csr_data
//
// One transaction is accepted per cycle while req_ready is high; its work goes
// into the queue and from there into the result register, where it is taken.
// The front end forms the error, integral and the three gain products in the
// accept cycle; the back end adds them into the duty when it pops the work.
// Reset is synchronous and clears all loop state and the queue.
// A two-entry queue and the result register let either side stall freely;
// req_ready drops only while the queue is full.
module fan_speed_pid_duty_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fspd_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fspd_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fspd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fspd_pkg::CSR_DATA_W-1:0] csr_data
);
   import fspd_pkg::*;

   cfg_type  cfg;
   logic     loop_clear;
   logic     push;
   work_type push_data;
   logic     queue_full;
   logic     pop;
   logic     work_valid;
   work_type work;

   // Configuration registers.
   fspd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .loop_clear (loop_clear)
   );

   // Front end.
   fspd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg),
      .loop_clear  (loop_clear),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // Queue between front and back.
   fspd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (work_valid),
      .pop_data  (work)
   );

   // Back end.
   fspd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .work_valid  (work_valid),
      .work        (work),
      .pop         (pop),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> sv/fspd_csr.sv
// Configuration register file of the fan speed PID duty controller.
module fspd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fspd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fspd_pkg::CSR_DATA_W-1:0] csr_data,
   output fspd_pkg::cfg_type             cfg,
   output logic                          loop_clear
);
   import fspd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            CSR_TARGET_SPEED:   cfg_in.target_speed   = csr_data[SPEED_W-1:0];
            CSR_GAIN_P:         cfg_in.gain_p         = csr_data[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_data[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_data[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data[LIMIT_W-1:0];
            CSR_DUTY_FLOOR:     cfg_in.duty_floor     = csr_data[DUTY_BITS-1:0];
            CSR_DUTY_CEILING:   cfg_in.duty_ceiling   = csr_data[DUTY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A zero target clears the loop memory right away.
   assign loop_clear = write_en && (csr_index == CSR_TARGET_SPEED)
                       && (csr_data[SPEED_W-1:0] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed   <= '0;
         cfg_ff.gain_p         <= GAIN_W'(410);
         cfg_ff.gain_i         <= GAIN_W'(82);
         cfg_ff.gain_d         <= GAIN_W'(41);
         cfg_ff.integral_limit <= LIMIT_W'(4000);
         cfg_ff.duty_floor     <= DUTY_BITS'(256);
         cfg_ff.duty_ceiling   <= DUTY_BITS'(1023);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/fspd_front.sv
// Front end: accepts transactions, tracks speed and integral, forms gain products.
module fspd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fspd_pkg::req_type req_payload,
   input  fspd_pkg::cfg_type cfg,
   input  logic              loop_clear,
   input  logic              queue_full,
   output logic              push,
   output fspd_pkg::work_type push_data
);
   import fspd_pkg::*;

   logic [SPEED_W-1:0]            speed_ff, speed_in;
   logic signed [INTEG_W-1:0]     integ_ff, integ_in;
   logic signed [ERR_W-1:0]       prev_err_ff, prev_err_in;

   logic [SPEED_W-1:0]            rpm_raw;
   logic signed [ERR_W-1:0]       err;
   logic signed [INTEG_SUM_W-1:0] integ_sum;
   logic signed [INTEG_SUM_W-1:0] lim_pos;
   logic signed [INTEG_SUM_W-1:0] lim_neg;
   logic signed [INTEG_SUM_W-1:0] integ_clamped;
   logic signed [DERIV_W-1:0]     deriv;
   logic                          is_tick;
   logic                          stop;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign is_tick   = (req_payload.command == CMD_TICK);
   assign stop      = is_tick && (cfg.target_speed == '0);

   // Pulse count to rpm; saturated to SPEED_MAX when stored as the speed.
   assign rpm_raw = SPEED_W'(req_payload.tach_pulses) * RPM_PER_PULSE;

   // Error, clamped integral and derivative of this tick.
   always_comb begin
      err       = ERR_W'($signed({1'b0, cfg.target_speed}))
                  - ERR_W'($signed({1'b0, speed_ff}));
      integ_sum = INTEG_SUM_W'(integ_ff) + INTEG_SUM_W'(err);
      lim_pos   = INTEG_SUM_W'($signed({1'b0, cfg.integral_limit}));
      lim_neg   = -lim_pos;
      integ_clamped = integ_sum;
      if (integ_clamped > lim_pos) begin
         integ_clamped = lim_pos;
      end
      if (integ_clamped < lim_neg) begin
         integ_clamped = lim_neg;
      end
      deriv = DERIV_W'(err) - DERIV_W'(prev_err_ff);
   end

   // Next loop state.
   always_comb begin
      speed_in    = speed_ff;
      integ_in    = integ_ff;
      prev_err_in = prev_err_ff;
      if (push) begin
         if (!is_tick) begin
            speed_in = (rpm_raw > SPEED_MAX) ? SPEED_MAX : rpm_raw;
         end else if (stop) begin
            integ_in    = '0;
            prev_err_in = '0;
         end else begin
            integ_in    = integ_clamped[INTEG_W-1:0];
            prev_err_in = err;
         end
      end
      if (loop_clear) begin
         integ_in    = '0;
         prev_err_in = '0;
      end
   end

   // Work for the back end: the three gain products and the reported state.
   always_comb begin
      push_data.tick      = is_tick;
      push_data.stop      = stop;
      push_data.prod_p    = $signed({1'b0, cfg.gain_p}) * err;
      push_data.prod_i    = $signed({1'b0, cfg.gain_i}) * integ_clamped;
      push_data.prod_d    = $signed({1'b0, cfg.gain_d}) * deriv;
      push_data.speed_rpm = speed_in;
      push_data.error_sum = integ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= '0;
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else begin
         speed_ff    <= speed_in;
         integ_ff    <= integ_in;
         prev_err_ff <= prev_err_in;
      end
   end

endmodule

>>> sv/fspd_queue.sv
// Two-entry queue that decouples the front end from the back end.
module fspd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fspd_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output fspd_pkg::work_type pop_data
);
   import fspd_pkg::*;

   work_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/fspd_back.sv
// Back end: sums the gain products, updates the duty and holds the result.
module fspd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   input  fspd_pkg::work_type work,
   output logic               pop,
   input  fspd_pkg::cfg_type  cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fspd_pkg::rsp_type  rsp_payload
);
   import fspd_pkg::*;

   localparam int ROUND_BIAS = (1 << GAIN_FRAC_BITS) - 1;

   logic [DUTY_BITS-1:0]     duty_ff, duty_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [PROD_W-1:0] sum;
   logic signed [PROD_W-1:0] sum_biased;
   logic signed [STEP_W-1:0] step;
   logic signed [NEXT_W-1:0] next;
   logic signed [NEXT_W-1:0] ceil_ext;
   logic signed [NEXT_W-1:0] floor_ext;

   // Take work whenever the result register is free or being drained.
   assign pop = work_valid && (!rsp_valid_ff || rsp_ready);

   // Duty step: sum truncated toward zero, then clamped (floor wins).
   always_comb begin
      sum        = work.prod_p + work.prod_i + work.prod_d;
      sum_biased = sum + (sum[PROD_W-1] ? PROD_W'(ROUND_BIAS) : '0);
      step       = STEP_W'(sum_biased >>> GAIN_FRAC_BITS);
      ceil_ext   = NEXT_W'($signed({1'b0, cfg.duty_ceiling}));
      floor_ext  = NEXT_W'($signed({1'b0, cfg.duty_floor}));
      next       = NEXT_W'($signed({1'b0, duty_ff})) + NEXT_W'(step);
      if (next > ceil_ext) begin
         next = ceil_ext;
      end
      if (next < floor_ext) begin
         next = floor_ext;
      end
   end

   // Next duty and result register.
   always_comb begin
      duty_in      = duty_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         if (work.tick) begin
            duty_in = work.stop ? '0 : next[DUTY_BITS-1:0];
         end
         rsp_in.duty      = duty_in;
         rsp_in.speed_rpm = work.speed_rpm;
         rsp_in.error_sum = work.error_sum;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload carries no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/fspd_checker.sv
// Port-level assertions for the fan speed PID duty controller, with its bind.
module fspd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input fspd_pkg::req_type               req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input fspd_pkg::rsp_type               rsp_payload
);
   import fspd_pkg::*;

   // Reset leaves no result transaction pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled input transaction holds its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("stalled input changed");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Reported speed never exceeds the saturation value.
   a_speed_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.speed_rpm <= SPEED_MAX)
      else $error("speed above saturation");

   // The integral is clamped symmetrically, so the most negative code never shows.
   a_integ_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.error_sum != 16'sh8000)
      else $error("integral outside symmetric clamp");

endmodule

bind fan_speed_pid_duty_controller fspd_checker u_fspd_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the fan speed PID duty controller.
module tb;
   import fspd_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the controller: registers and loop state.
   cfg_type cfg_now;
   logic [SPEED_W-1:0] speed_now;
   logic [DUTY_BITS-1:0] duty_now;
   logic signed [INTEG_W-1:0] integral_now;
   logic signed [ERR_W-1:0] last_error;

   req_type commands_to_send[$];
   rsp_type status_due[$];
   int commands_queued = 0;
   int commands_taken = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int rsp_wait = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   fan_speed_pid_duty_controller uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Runs one command through the shadow loop and returns the status it reports.
   function automatic rsp_type advance_fan_loop(req_type cmd_in);
      longint rpm, err, integ, deriv, lim, total, step, next;
      rsp_type status;
      if (cmd_in.command == CMD_MEASURE) begin
         rpm = longint'(cmd_in.tach_pulses) * longint'(RPM_PER_PULSE);
         if (rpm > longint'(SPEED_MAX)) rpm = longint'(SPEED_MAX);
         speed_now = rpm[SPEED_W-1:0];
      end else if (cfg_now.target_speed == '0) begin
         // A stopped fan clears the whole loop.
         duty_now = '0;
         integral_now = '0;
         last_error = '0;
      end else begin
         err = longint'(cfg_now.target_speed) - longint'(speed_now);
         lim = longint'(cfg_now.integral_limit);
         integ = longint'(integral_now) + err;
         if (integ > lim) integ = lim;
         if (integ < -lim) integ = -lim;
         deriv = err - longint'(last_error);
         total = longint'(cfg_now.gain_p) * err + longint'(cfg_now.gain_i) * integ
               + longint'(cfg_now.gain_d) * deriv;
         step = total / (longint'(1) << GAIN_FRAC_BITS);
         next = longint'(duty_now) + step;
         // Ceiling first, then floor, so a crossed floor wins.
         if (next > longint'(cfg_now.duty_ceiling)) next = longint'(cfg_now.duty_ceiling);
         if (next < longint'(cfg_now.duty_floor)) next = longint'(cfg_now.duty_floor);
         duty_now = next[DUTY_BITS-1:0];
         integral_now = integ[INTEG_W-1:0];
         last_error = err[ERR_W-1:0];
      end
      status.duty = duty_now;
      status.speed_rpm = speed_now;
      status.error_sum = integral_now;
      return status;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (mismatches < 40) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic queue_command(logic cmd, int pulses);
      req_type item;
      item.command = cmd;
      item.tach_pulses = pulses[PULSE_W-1:0];
      commands_to_send.push_back(item);
      commands_queued++;
   endtask

   // Writes one register through the configuration channel and mirrors it.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      repeat ($urandom_range(1, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_TARGET_SPEED: begin
            cfg_now.target_speed = data;
            if (data == '0) begin
               integral_now = '0;
               last_error = '0;
            end
         end
         CSR_GAIN_P:         cfg_now.gain_p = data;
         CSR_GAIN_I:         cfg_now.gain_i = data;
         CSR_GAIN_D:         cfg_now.gain_d = data;
         CSR_INTEGRAL_LIMIT: cfg_now.integral_limit = data[LIMIT_W-1:0];
         CSR_DUTY_FLOOR:     cfg_now.duty_floor = data[DUTY_BITS-1:0];
         CSR_DUTY_CEILING:   cfg_now.duty_ceiling = data[DUTY_BITS-1:0];
         default: ;
      endcase
   endtask

   // Waits until every queued command has been taken and every status has come back.
   task automatic drain();
      while (commands_taken != commands_queued || status_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return GAIN_W'($urandom_range(0, 65535));
         default: return GAIN_W'($urandom_range(0, 3000));
      endcase
   endfunction

   // Draws a fresh register setting, extremes included.
   task automatic random_config();
      logic [CSR_DATA_W-1:0] data;
      csr_write(CSR_GAIN_P, pick_gain());
      csr_write(CSR_GAIN_I, pick_gain());
      csr_write(CSR_GAIN_D, pick_gain());
      case ($urandom_range(0, 4))
         0:       data = '0;
         1:       data = 16'hFFFF;
         2:       data = CSR_DATA_W'($urandom_range(0, 65535));
         default: data = CSR_DATA_W'($urandom_range(0, 8000));
      endcase
      csr_write(CSR_INTEGRAL_LIMIT, data);
      case ($urandom_range(0, 4))
         0: begin
            csr_write(CSR_DUTY_FLOOR, CSR_DATA_W'($urandom_range(0, 65535)));
            csr_write(CSR_DUTY_CEILING, CSR_DATA_W'($urandom_range(0, 65535)));
         end
         1: begin
            csr_write(CSR_DUTY_FLOOR, '0);
            csr_write(CSR_DUTY_CEILING, 16'hFFFF);
         end
         default: begin
            data = {6'($urandom_range(0, 63)), 10'($urandom_range(0, 400))};
            csr_write(CSR_DUTY_FLOOR, data);
            data = {6'($urandom_range(0, 63)), 10'($urandom_range(600, 1023))};
            csr_write(CSR_DUTY_CEILING, data);
         end
      endcase
      if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
      case ($urandom_range(0, 7))
         0:       data = '0;
         1:       data = 16'hFFFF;
         2:       data = CSR_DATA_W'($urandom_range(0, 65535));
         default: data = CSR_DATA_W'($urandom_range(300, 9000));
      endcase
      csr_write(CSR_TARGET_SPEED, data);
   endtask

   // Mostly measure-then-tick loops near the target, with some raw noise.
   task automatic random_phase(int count);
      int n, base, pulses;
      random_config();
      base = int'(cfg_now.target_speed) / 60;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) < 7) begin
            pulses = base + int'($urandom_range(0, 40)) - 20;
            if (pulses < 0) pulses = 0;
            if (pulses > 1023) pulses = 1023;
            queue_command(CMD_MEASURE, pulses);
            n++;
            repeat ($urandom_range(1, 3)) begin
               queue_command(CMD_TICK, $urandom_range(0, 1023));
               n++;
            end
         end else begin
            queue_command(logic'($urandom_range(0, 1)), $urandom_range(0, 1023));
            n++;
         end
      end
      drain();
   endtask

   // Input driver: sends queued commands with random gaps between transactions.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            status_due.push_back(advance_fan_loop(req_payload));
            commands_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (commands_to_send.size() > 0) begin
               req_payload <= commands_to_send.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
               req_gap = req_calm ? 0 : $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stalls at random and checks each status transaction in order.
   always @(posedge clock) begin : status_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               report_mismatch("status with none awaited, duty", rsp_payload.duty, 0);
            end else begin
               want = status_due.pop_front();
               if (rsp_payload.duty != want.duty)
                  report_mismatch("duty", rsp_payload.duty, want.duty);
               if (rsp_payload.speed_rpm != want.speed_rpm)
                  report_mismatch("speed_rpm", rsp_payload.speed_rpm, want.speed_rpm);
               if (rsp_payload.error_sum != want.error_sum)
                  report_mismatch("error_sum", rsp_payload.error_sum, want.error_sum);
            end
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 6);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      cfg_now.target_speed = '0;
      cfg_now.gain_p = 16'd410;
      cfg_now.gain_i = 16'd82;
      cfg_now.gain_d = 16'd41;
      cfg_now.integral_limit = 15'd4000;
      cfg_now.duty_floor = 10'd256;
      cfg_now.duty_ceiling = 10'd1023;
      speed_now = '0;
      duty_now = '0;
      integral_now = '0;
      last_error = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a tick at zero target, speed conversion and saturation.
      queue_command(CMD_MEASURE, 0);
      queue_command(CMD_TICK, 1023);
      queue_command(CMD_MEASURE, 1000);
      queue_command(CMD_MEASURE, 1001);
      queue_command(CMD_MEASURE, 1023);
      queue_command(CMD_TICK, 0);
      drain();

      // Running loop with default gains, error of both signs.
      csr_write(CSR_TARGET_SPEED, 16'd3000);
      queue_command(CMD_MEASURE, 10);
      repeat (3) queue_command(CMD_TICK, $urandom_range(0, 1023));
      queue_command(CMD_MEASURE, 50);
      queue_command(CMD_TICK, $urandom_range(0, 1023));
      queue_command(CMD_MEASURE, 1023);
      repeat (2) queue_command(CMD_TICK, $urandom_range(0, 1023));
      drain();

      // Largest gains and limit, floor set above the ceiling.
      csr_write(CSR_GAIN_P, 16'hFFFF);
      csr_write(CSR_GAIN_I, 16'hFFFF);
      csr_write(CSR_GAIN_D, 16'hFFFF);
      csr_write(CSR_INTEGRAL_LIMIT, 16'hFFFF);
      csr_write(CSR_DUTY_FLOOR, 16'd900);
      csr_write(CSR_DUTY_CEILING, 16'd100);
      csr_write(CSR_TARGET_SPEED, 16'hFFFF);
      queue_command(CMD_MEASURE, 0);
      repeat (2) queue_command(CMD_TICK, $urandom_range(0, 1023));
      queue_command(CMD_MEASURE, 1023);
      queue_command(CMD_TICK, $urandom_range(0, 1023));
      drain();

      // Writing a zero target clears the integral at once; duty holds until a tick.
      csr_write(CSR_TARGET_SPEED, '0);
      csr_write(CSR_UNUSED_INDEX, 16'hFFFF);
      queue_command(CMD_MEASURE, 512);
      queue_command(CMD_TICK, $urandom_range(0, 1023));
      drain();

      // Zero gains and limit, zero duty range, values masked to register widths.
      csr_write(CSR_GAIN_P, '0);
      csr_write(CSR_GAIN_I, '0);
      csr_write(CSR_GAIN_D, '0);
      csr_write(CSR_INTEGRAL_LIMIT, 16'h8000);
      csr_write(CSR_DUTY_FLOOR, 16'hFC00);
      csr_write(CSR_DUTY_CEILING, 16'hFC00);
      csr_write(CSR_TARGET_SPEED, 16'd1);
      queue_command(CMD_MEASURE, 0);
      repeat (2) queue_command(CMD_TICK, $urandom_range(0, 1023));
      drain();

      repeat (8) random_phase(50);

      if (status_due.size() != 0) report_mismatch("statuses never returned", status_due.size(), 0);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/fspd_pkg.sv
sv/fspd_csr.sv
sv/fspd_front.sv
sv/fspd_queue.sv
sv/fspd_back.sv
sv/fan_speed_pid_duty_controller.sv
sv/fspd_checker.sv
tb/tb.sv
